@@ rtl/utf8d_pkg.sv @@
// utf8d_pkg: types and constants shared by the UTF-8 byte stream decoder.
// No dependencies.

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned RemW   = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = 2;

  localparam logic [CpW-1:0] ReplChar = CpW'(32'hFFFD);

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_repl;
    logic           last_of_run;
  } result_t;

  typedef struct packed {
    logic [QCntW-1:0]       num;
    result_t [QDepth-1:0]   res;
    logic [CpW-1:0]         acc_next;
    logic [RemW-1:0]        rem_next;
  } dec_t;

  function automatic result_t make_result(logic [CpW-1:0] cp, logic repl);
    result_t r;
    r.code_point  = cp;
    r.is_repl     = repl;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/utf8d_decode.sv @@
// utf8d_decode: classifies one byte against the pending sequence state and
// forms up to two results plus the next state. Depends on utf8d_pkg.

module utf8d_decode (
  input  logic [utf8d_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  input  logic [utf8d_pkg::CpW-1:0]   acc_i,
  input  logic [utf8d_pkg::RemW-1:0]  rem_i,
  output utf8d_pkg::dec_t             dec_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  acc_n;
  logic [RemW-1:0] rem_n;
  logic [QCntW-1:0] num;
  result_t r0, r1;

  always_comb begin
    acc_n = acc_i;
    rem_n = rem_i;
    num   = '0;
    r0    = make_result(ReplChar, 1'b1);
    r1    = make_result(ReplChar, 1'b1);

    if (byte_i[7] == 1'b0) begin
      if (rem_i != '0) begin
        r1    = make_result(CpW'(byte_i), 1'b0);
        num   = QCntW'(2);
        rem_n = '0;
      end else begin
        r0  = make_result(CpW'(byte_i), 1'b0);
        num = QCntW'(1);
      end
    end else if (byte_i[7:6] == 2'b10) begin
      if (rem_i != '0) begin
        acc_n = {acc_i[CpW-7:0], byte_i[5:0]};
        rem_n = rem_i - RemW'(1);
        if (rem_i == RemW'(1)) begin
          r0  = make_result(acc_n, 1'b0);
          num = QCntW'(1);
        end
      end else begin
        num = QCntW'(1);
      end
    end else if (byte_i[7:5] == 3'b110) begin
      rem_n = RemW'(1);
      acc_n = CpW'(byte_i[4:0]);
    end else if (byte_i[7:4] == 4'b1110) begin
      rem_n = RemW'(2);
      acc_n = CpW'(byte_i[3:0]);
    end else if (byte_i[7:3] == 5'b11110) begin
      rem_n = RemW'(3);
      acc_n = CpW'(byte_i[2:0]);
    end else begin
      num   = QCntW'(1);
      rem_n = '0;
    end

    // unfinished sequence at end of stream
    if (last_i && rem_n != '0) begin
      if (num == '0) r0 = make_result(ReplChar, 1'b1);
      else           r1 = make_result(ReplChar, 1'b1);
      num   = num + QCntW'(1);
      rem_n = '0;
      acc_n = '0;
    end

    if (num == QCntW'(1)) r0.last_of_run = 1'b1;
    if (num == QCntW'(2)) r1.last_of_run = 1'b1;
  end

  assign dec_o.num      = num;
  assign dec_o.res      = {r1, r0};
  assign dec_o.acc_next = acc_n;
  assign dec_o.rem_next = rem_n;

endmodule

@@ rtl/utf8d_outq.sv @@
// utf8d_outq: two-entry result queue; takes up to two results per transfer
// in and presents one per cycle while pop_i is high. Depends on utf8d_pkg.

module utf8d_outq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_req_i,
  input  logic [utf8d_pkg::QCntW-1:0]          push_n_i,
  input  utf8d_pkg::result_t [utf8d_pkg::QDepth-1:0] push_data_i,
  output logic                                 push_ok_o,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output utf8d_pkg::result_t                   head_o
);
  import utf8d_pkg::*;

  result_t [QDepth-1:0] ent_q, ent_d, shifted;
  logic [QCntW-1:0]     cnt_q, cnt_d, rem_cnt, idx;
  logic                 do_push;

  assign rem_cnt   = cnt_q - QCntW'(pop_i);
  assign push_ok_o = ({1'b0, push_n_i} + {1'b0, rem_cnt}) <= (QCntW+1)'(QDepth);
  assign do_push   = push_req_i && push_ok_o;

  always_comb begin
    shifted[0] = pop_i ? ent_q[1] : ent_q[0];
    shifted[1] = ent_q[1];
    ent_d      = shifted;
    idx        = '0;
    for (int i = 0; i < QDepth; i++) begin
      idx = QCntW'(i) - rem_cnt;
      if (QCntW'(i) >= rem_cnt && do_push && idx < push_n_i) begin
        ent_d[i] = push_data_i[idx[0]];
      end
    end
    cnt_d = rem_cnt + (do_push ? push_n_i : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[0];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("result queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty result queue");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !pop_i && push_n_i != '0) |=> cnt_q != '0)
    else $error("pushed results lost");

endmodule

@@ rtl/utf8_byte_stream_decoder.sv @@
// utf8_byte_stream_decoder: lax UTF-8 decoder, one byte in, up to two code points out.
// A byte waits in the s1 register; its results are registered in the result queue.
// Throughput: one byte per cycle while the queue has room; the two-entry queue drains
// one result a cycle while out_ready_i is high; two-result bytes can stall the input.
// Reset clears the sequence count, accumulator and queue at once; no clearing pass.
// Depends on utf8d_pkg, utf8d_decode, utf8d_outq.

module utf8_byte_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0]  data_byte_i,
  input  logic                         is_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]    code_point_o,
  output logic                         is_replacement_o,
  output logic                         last_of_run_o
);
  import utf8d_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic [CpW-1:0]   acc_q, acc_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             s1_adv, push_ok, pop, in_xfer;
  dec_t             dec;
  result_t          head;

  utf8d_decode u_decode (
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .acc_i  (acc_q),
    .rem_i  (rem_q),
    .dec_o  (dec)
  );

  utf8d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_req_i  (s1_valid_q),
    .push_n_i    (dec.num),
    .push_data_i (dec.res),
    .push_ok_o   (push_ok),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .head_o      (head)
  );

  assign pop        = out_valid_o && out_ready_i;
  assign s1_adv     = s1_valid_q && push_ok;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_adv);
  assign acc_d      = s1_adv ? dec.acc_next : acc_q;
  assign rem_d      = s1_adv ? dec.rem_next : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      rem_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      acc_q      <= acc_d;
      rem_q      <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= is_last_i;
    end
  end

  assign code_point_o     = head.code_point;
  assign is_replacement_o = head.is_repl;
  assign last_of_run_o    = head.last_of_run;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> rem_q == '0) else $error("sequence pending after last byte");
  a_pair_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && dec.num == QCntW'(2)) |-> (dec.res[0].is_repl && dec.res[1].last_of_run))
    else $error("two-result transfer without leading replacement");
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> (rem_q == $past(rem_q) && acc_q == $past(acc_q)))
    else $error("decoder state moved without a transfer");

endmodule
